// File: rtl/pulse_width_sensor_frame_decoder_defines.svh
// ---------------------------------------------------------------------------
// Pulse width sensor frame decoder: assertion macros
// Shared concurrent assertion forms for the decoder RTL.
// ---------------------------------------------------------------------------
`ifndef PULSE_WIDTH_SENSOR_FRAME_DECODER_DEFINES_SVH
`define PULSE_WIDTH_SENSOR_FRAME_DECODER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PWSFD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pwsfd assertion failed");

// next-cycle implication, disabled during reset
`define PWSFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pwsfd assertion failed");

`endif

// File: rtl/pwsfd_pkg.sv
// ---------------------------------------------------------------------------
// Pulse width sensor frame decoder package
// Frame geometry, register indexes, status codes and shared structs.
// ---------------------------------------------------------------------------
package pwsfd_pkg;

  localparam int DATA_BITS     = 32;
  localparam int PREAMBLE_BITS = 4;
  localparam int FRAME_BITS    = DATA_BITS + PREAMBLE_BITS;
  localparam int IDX_W         = $clog2(FRAME_BITS + 1);
  localparam int DATA_IDX_W    = (DATA_BITS > 1) ? $clog2(DATA_BITS) : 1;
  localparam int PRE_IDX_W     = (PREAMBLE_BITS > 1) ? $clog2(PREAMBLE_BITS) : 1;

  localparam int RUN_W    = 8;
  localparam int PRE_W    = 4;
  localparam int CFG_A_W  = 3;
  localparam int CFG_D_W  = 8;

  localparam logic [RUN_W-1:0] LONG_MIN_RST  = 8'd30;
  localparam logic [RUN_W-1:0] LONG_MAX_RST  = 8'd40;
  localparam logic [RUN_W-1:0] SHORT_MIN_RST = 8'd10;
  localparam logic [RUN_W-1:0] SHORT_MAX_RST = 8'd20;
  localparam logic [PRE_W-1:0] PREAMBLE_RST  = 4'hC;

  typedef enum logic [CFG_A_W-1:0] {
    CFG_LONG_MIN  = 3'd0,
    CFG_LONG_MAX  = 3'd1,
    CFG_SHORT_MIN = 3'd2,
    CFG_SHORT_MAX = 3'd3,
    CFG_PREAMBLE  = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_PREAMBLE = 2'd2
  } status_t;

  typedef struct packed {
    logic [RUN_W-1:0] long_min;
    logic [RUN_W-1:0] long_max;
    logic [RUN_W-1:0] short_min;
    logic [RUN_W-1:0] short_max;
    logic [PRE_W-1:0] expected_preamble;
  } pwsfd_cfg_t;

  typedef struct packed {
    logic bit_ok;
    logic bit_val;
    logic half_start;
  } pwsfd_class_t;

endpackage

// File: rtl/pulse_width_sensor_frame_decoder.sv
// Path: a run length is held in the input register; a frame result then goes
//   out through the result register.
// Throughput: one run length per cycle; only a stalled result register holds input.
// Reset: synchronous, active low; clears the frame state and loads the window
//   and preamble registers with their defaults.
// ---------------------------------------------------------------------------
// Pulse width sensor frame decoder
// Decodes pulse-width coded run lengths into a data word and preamble check.
// ---------------------------------------------------------------------------
`include "pulse_width_sensor_frame_decoder_defines.svh"

module pulse_width_sensor_frame_decoder
  import pwsfd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_A_W-1:0]   cfg_addr,
  input  logic [CFG_D_W-1:0]   cfg_data,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [RUN_W-1:0]     in_tdata,   // [7:0] run_length
  input  logic [0:0]           in_tuser,   // [0] frame_start
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [DATA_BITS-1:0] out_tdata,  // [31:0] frame_data
  output logic [1:0]           out_tuser   // [1:0] status
);

  pwsfd_cfg_t cfg_r, cfg_nxt;

  logic                     s1_valid_r, s1_valid_nxt;
  logic                     s1_start_r;
  logic [RUN_W-1:0]         s1_run_r;

  logic                     frame_active_r, frame_active_nxt;
  logic                     half_r, half_nxt;
  logic [IDX_W-1:0]         bit_index_r, bit_index_nxt;
  logic [DATA_BITS-1:0]     data_r, data_nxt;
  logic [PREAMBLE_BITS-1:0] pre_r, pre_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic [DATA_BITS-1:0]     out_data_r, out_data_nxt;
  status_t                  out_status_r, out_status_nxt;

  logic                     in_fire;
  logic                     adv;
  logic                     s1_fire;
  logic                     emit;

  logic                     active_eff;
  logic                     half_eff;
  logic [IDX_W-1:0]         idx_eff;
  logic [DATA_BITS-1:0]     data_eff;
  logic [PREAMBLE_BITS-1:0] pre_eff;
  logic [IDX_W-1:0]         pre_off;
  logic [DATA_BITS-1:0]     data_upd;
  logic [PREAMBLE_BITS-1:0] pre_upd;
  pwsfd_class_t             cls;

  assign cfg_ready  = 1'b1;
  assign adv        = !out_valid_r || out_tready;
  assign s1_fire    = s1_valid_r && adv;
  assign in_tready  = !s1_valid_r || adv;
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_addr))
        CFG_LONG_MIN:  cfg_nxt.long_min          = cfg_data;
        CFG_LONG_MAX:  cfg_nxt.long_max          = cfg_data;
        CFG_SHORT_MIN: cfg_nxt.short_min         = cfg_data;
        CFG_SHORT_MAX: cfg_nxt.short_max         = cfg_data;
        CFG_PREAMBLE:  cfg_nxt.expected_preamble = cfg_data[PRE_W-1:0];
        default: ;
      endcase
    end
  end

  assign active_eff = s1_start_r || frame_active_r;
  assign half_eff   = s1_start_r ? 1'b0 : half_r;
  assign idx_eff    = s1_start_r ? '0 : bit_index_r;
  assign data_eff   = s1_start_r ? '0 : data_r;
  assign pre_eff    = s1_start_r ? '0 : pre_r;
  assign pre_off    = idx_eff - IDX_W'(DATA_BITS);

  pwsfd_classify u_classify (
    .run_length   (s1_run_r),
    .cfg          (cfg_r),
    .half_pending (half_eff),
    .cls          (cls)
  );

  always_comb begin
    data_upd = data_eff;
    pre_upd  = pre_eff;
    if (idx_eff < IDX_W'(DATA_BITS)) begin
      data_upd = data_eff | (DATA_BITS'(cls.bit_val) << idx_eff[DATA_IDX_W-1:0]);
    end else begin
      pre_upd = pre_eff | (PREAMBLE_BITS'(cls.bit_val) << pre_off[PRE_IDX_W-1:0]);
    end
  end

  always_comb begin
    s1_valid_nxt     = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_r);
    frame_active_nxt = frame_active_r;
    half_nxt         = half_r;
    bit_index_nxt    = bit_index_r;
    data_nxt         = data_r;
    pre_nxt          = pre_r;
    emit             = 1'b0;
    out_data_nxt     = out_data_r;
    out_status_nxt   = out_status_r;

    if (s1_fire && active_eff) begin
      frame_active_nxt = 1'b1;
      half_nxt         = cls.half_start;
      bit_index_nxt    = idx_eff;
      data_nxt         = data_eff;
      pre_nxt          = pre_eff;
      if (cls.bit_ok) begin
        bit_index_nxt = idx_eff + IDX_W'(1);
        data_nxt      = data_upd;
        pre_nxt       = pre_upd;
        if (idx_eff == IDX_W'(FRAME_BITS - 1)) begin
          emit           = 1'b1;
          out_data_nxt   = data_upd;
          out_status_nxt = (PRE_W'(pre_upd) == cfg_r.expected_preamble) ? ST_OK : ST_PREAMBLE;
        end
      end else if (!cls.half_start) begin
        emit           = 1'b1;
        out_data_nxt   = '0;
        out_status_nxt = ST_INVALID;
      end
      if (emit) begin
        frame_active_nxt = 1'b0;
        half_nxt         = 1'b0;
        bit_index_nxt    = '0;
        data_nxt         = '0;
        pre_nxt          = '0;
      end
    end

    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.long_min          <= LONG_MIN_RST;
      cfg_r.long_max          <= LONG_MAX_RST;
      cfg_r.short_min         <= SHORT_MIN_RST;
      cfg_r.short_max         <= SHORT_MAX_RST;
      cfg_r.expected_preamble <= PREAMBLE_RST;
      s1_valid_r              <= 1'b0;
      frame_active_r          <= 1'b0;
      half_r                  <= 1'b0;
      bit_index_r             <= '0;
      data_r                  <= '0;
      pre_r                   <= '0;
      out_valid_r             <= 1'b0;
    end else begin
      cfg_r          <= cfg_nxt;
      s1_valid_r     <= s1_valid_nxt;
      frame_active_r <= frame_active_nxt;
      half_r         <= half_nxt;
      bit_index_r    <= bit_index_nxt;
      data_r         <= data_nxt;
      pre_r          <= pre_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_start_r <= in_tuser[0];
      s1_run_r   <= in_tdata;
    end
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
  end

  `PWSFD_ASSERT_NOW(a_invalid_zero_data, clk, rst_n,
    out_tvalid && (out_tuser == ST_INVALID), out_tdata == '0)
  `PWSFD_ASSERT_NOW(a_idle_cleared, clk, rst_n,
    !frame_active_r, (bit_index_r == '0) && !half_r && (data_r == '0))
  `PWSFD_ASSERT_NOW(a_index_bound, clk, rst_n,
    frame_active_r, bit_index_r < IDX_W'(FRAME_BITS))
  `PWSFD_ASSERT_NEXT(a_result_ends_frame, clk, rst_n,
    emit, !frame_active_r && out_tvalid)
  `PWSFD_ASSERT_NOW(a_stall_holds_input, clk, rst_n,
    s1_valid_r && out_valid_r && !out_tready, !in_tready)

endmodule

// File: rtl/pwsfd_classify.sv
// ---------------------------------------------------------------------------
// Pulse width sensor frame decoder: run classifier
// Tests one run length against the long and short windows.
// ---------------------------------------------------------------------------
module pwsfd_classify
  import pwsfd_pkg::*;
(
  input  logic [RUN_W-1:0] run_length,
  input  pwsfd_cfg_t       cfg,
  input  logic             half_pending,
  output pwsfd_class_t     cls
);

  logic in_long;
  logic in_short;

  assign in_long  = (run_length >= cfg.long_min) && (run_length <= cfg.long_max);
  assign in_short = (run_length >= cfg.short_min) && (run_length <= cfg.short_max);

  always_comb begin
    cls = '0;
    if (half_pending) begin
      cls.bit_ok  = in_short;
      cls.bit_val = 1'b1;
    end else if (in_long) begin
      cls.bit_ok  = 1'b1;
      cls.bit_val = 1'b0;
    end else if (in_short) begin
      cls.half_start = 1'b1;
    end
  end

endmodule

// File: tb/tb_pulse_width_sensor_frame_decoder.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Pulse width sensor frame decoder testbench
// Sends run lengths through the input stream. Most of them form well-built
// frames with random data and preamble; the rest are noise, broken bits and
// cut-off frames. The window and preamble registers change between phases.
// An in-bench decoder predicts every frame result; each result is compared with
// the oldest prediction. Both sides idle in random bursts bar the last test.
// ---------------------------------------------------------------------------
module tb_pulse_width_sensor_frame_decoder;
  import pwsfd_pkg::*;

  localparam int QUIET_LIMIT    = 1000;
  localparam int ITEM_TARGET    = 1250;
  localparam int PHASE_ITEMS    = 90;
  localparam int REPORT_LIMIT   = 10;

  typedef struct {
    status_t              status;
    logic [DATA_BITS-1:0] data;
  } frame_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_A_W-1:0]   cfg_addr;
  logic [CFG_D_W-1:0]   cfg_data;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [RUN_W-1:0]     in_tdata;   // [7:0] run_length
  logic [0:0]           in_tuser;   // [0] frame_start
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [DATA_BITS-1:0] out_tdata;  // [31:0] frame_data
  logic [1:0]           out_tuser;  // [1:0] status

  pwsfd_cfg_t           windows;
  logic                 frame_on;
  logic                 half_pending;
  int unsigned          bits_done;
  logic [DATA_BITS-1:0] word_acc;
  logic [PRE_W-1:0]     preamble_acc;

  frame_result_t        frames_due[$];
  logic [RUN_W-1:0]     zero_runs[$];
  logic [RUN_W-1:0]     lead_runs[$];
  logic [RUN_W-1:0]     half_runs[$];
  logic [RUN_W-1:0]     wild_runs[$];
  logic [RUN_W-1:0]     off_short_runs[$];

  bit          tx_gaps_on;
  bit          rx_stalls_on;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned mismatches;
  int unsigned frames_built;

  pulse_width_sensor_frame_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #10 clk = ~clk;

  function automatic bit in_win(input logic [RUN_W-1:0] v, input logic [RUN_W-1:0] lo,
                                input logic [RUN_W-1:0] hi);
    return (v >= lo) && (v <= hi);
  endfunction

  function automatic logic [RUN_W-1:0] pick(input logic [RUN_W-1:0] pool[$]);
    return pool[$urandom_range(pool.size() - 1, 0)];
  endfunction

  task automatic clear_frame_state();
    bits_done    = 0;
    word_acc     = '0;
    preamble_acc = '0;
    half_pending = 1'b0;
  endtask

  task automatic push_result(input status_t st, input logic [DATA_BITS-1:0] data);
    frame_result_t r;
    r.status = st;
    r.data   = data;
    frames_due.push_back(r);
    clear_frame_state();
    frame_on = 1'b0;
  endtask

  task automatic decode_run(input logic start, input logic [RUN_W-1:0] run);
    bit got;
    bit val;
    got = 1'b0;
    val = 1'b0;
    if (start) begin
      clear_frame_state();
      frame_on = 1'b1;
    end
    if (!frame_on) return;
    if (half_pending) begin
      half_pending = 1'b0;
      if (in_win(run, windows.short_min, windows.short_max)) begin
        got = 1'b1;
        val = 1'b1;
      end
    end else if (in_win(run, windows.long_min, windows.long_max)) begin
      got = 1'b1;
    end else if (in_win(run, windows.short_min, windows.short_max)) begin
      half_pending = 1'b1;
      return;
    end
    if (!got) begin
      push_result(ST_INVALID, '0);
      return;
    end
    if (bits_done < DATA_BITS) word_acc[bits_done] = val;
    else preamble_acc[bits_done - DATA_BITS] = val;
    bits_done++;
    if (bits_done >= FRAME_BITS) begin
      push_result((preamble_acc == windows.expected_preamble) ? ST_OK : ST_PREAMBLE, word_acc);
    end
  endtask

  task automatic send_run(input logic start, input logic [RUN_W-1:0] run);
    if (tx_gaps_on && $urandom_range(3, 0) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= run;
    in_tuser  <= start;
    do @(posedge clk); while (!(in_tvalid && in_tready));
    decode_run(start, run);
    items_sent++;
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_D_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    case (idx)
      CFG_LONG_MIN:  windows.long_min = val;
      CFG_LONG_MAX:  windows.long_max = val;
      CFG_SHORT_MIN: windows.short_min = val;
      CFG_SHORT_MAX: windows.short_max = val;
      CFG_PREAMBLE:  windows.expected_preamble = val[PRE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_windows(input logic [RUN_W-1:0] lmin, input logic [RUN_W-1:0] lmax,
                                 input logic [RUN_W-1:0] smin, input logic [RUN_W-1:0] smax,
                                 input logic [PRE_W-1:0] pre);
    int v;
    logic [RUN_W-1:0] rv;
    wait_idle();
    write_reg(CFG_LONG_MIN, lmin);
    write_reg(CFG_LONG_MAX, lmax);
    write_reg(CFG_SHORT_MIN, smin);
    write_reg(CFG_SHORT_MAX, smax);
    write_reg(CFG_PREAMBLE, {4'($urandom), pre});
    cfg_valid <= 1'b0;
    zero_runs.delete();
    lead_runs.delete();
    half_runs.delete();
    wild_runs.delete();
    off_short_runs.delete();
    for (v = 0; v < 256; v++) begin
      rv = RUN_W'(v);
      if (in_win(rv, lmin, lmax)) zero_runs.push_back(rv);
      if (in_win(rv, smin, smax)) half_runs.push_back(rv);
      else off_short_runs.push_back(rv);
      if (in_win(rv, smin, smax) && !in_win(rv, lmin, lmax)) lead_runs.push_back(rv);
      if (!in_win(rv, smin, smax) && !in_win(rv, lmin, lmax)) wild_runs.push_back(rv);
    end
  endtask

  task automatic send_bit(input logic start, input bit val);
    if ((val || zero_runs.size() == 0) && lead_runs.size() != 0) begin
      send_run(start, pick(lead_runs));
      send_run(1'b0, pick(half_runs));
    end else if (zero_runs.size() != 0) begin
      send_run(start, pick(zero_runs));
    end else begin
      send_run(start, RUN_W'($urandom));
    end
  endtask

  task automatic send_bad_bit(input logic start);
    if ($urandom_range(1, 0) == 1 && lead_runs.size() != 0 && off_short_runs.size() != 0) begin
      send_run(start, pick(lead_runs));
      send_run(1'b0, pick(off_short_runs));
    end else if (wild_runs.size() != 0) begin
      send_run(start, pick(wild_runs));
    end
  endtask

  task automatic send_frame();
    logic [FRAME_BITS-1:0] bits;
    int cut;
    int bad;
    int pos;
    bits[DATA_BITS-1:0] = $urandom;
    bits[FRAME_BITS-1:DATA_BITS] = frames_built[0] ? PRE_W'($urandom)
                                                   : windows.expected_preamble;
    frames_built++;
    cut = ($urandom_range(9, 0) == 0) ? $urandom_range(FRAME_BITS - 1, 1) : FRAME_BITS;
    bad = ($urandom_range(5, 0) == 0) ? $urandom_range(FRAME_BITS - 1, 0) : -1;
    for (pos = 0; pos < cut; pos++) begin
      if (pos == bad) begin
        send_bad_bit(pos == 0);
        break;
      end
      send_bit(pos == 0, bits[pos]);
    end
  endtask

  task automatic send_noise(input int count);
    repeat (count) send_run($urandom_range(7, 0) == 0, RUN_W'($urandom));
  endtask

  task automatic run_phase(input int budget);
    int unsigned start_items;
    start_items = items_sent;
    while (items_sent - start_items < budget) begin
      if ($urandom_range(4, 0) == 0) send_noise($urandom_range(6, 1));
      else send_frame();
    end
  endtask

  task automatic test_default_windows();
    send_run(1'b0, 8'd35);
    send_run(1'b0, 8'd255);
    send_run(1'b1, 8'd0);
    send_run(1'b1, 8'd255);
    send_run(1'b1, 8'd15);
    send_run(1'b0, 8'd50);
    send_run(1'b1, 8'd10);
    send_run(1'b0, 8'd20);
    send_run(1'b0, 8'd30);
    send_run(1'b0, 8'd40);
    send_run(1'b1, 8'd20);
    send_run(1'b0, 8'd9);
    send_run(1'b1, 8'd41);
    send_run(1'b1, 8'd29);
    send_run(1'b1, 8'd21);
  endtask

  task automatic test_overlapping_windows();
    program_windows(8'd10, 8'd30, 8'd20, 8'd40, 4'h0);
    send_run(1'b1, 8'd25);
    send_run(1'b0, 8'd35);
    send_run(1'b0, 8'd20);
    send_run(1'b0, 8'd31);
    send_run(1'b0, 8'd41);
    send_run(1'b1, 8'd9);
  endtask

  task automatic test_window_settings();
    logic [RUN_W-1:0] a;
    logic [RUN_W-1:0] b;
    logic [RUN_W-1:0] c;
    logic [RUN_W-1:0] d;
    program_windows(LONG_MIN_RST, LONG_MAX_RST, SHORT_MIN_RST, SHORT_MAX_RST, PREAMBLE_RST);
    run_phase(PHASE_ITEMS);
    program_windows(8'd10, 8'd30, 8'd20, 8'd40, 4'hF);
    run_phase(PHASE_ITEMS);
    program_windows(8'd255, 8'd255, 8'd0, 8'd0, 4'h0);
    run_phase(PHASE_ITEMS);
    program_windows(8'd0, 8'd255, 8'd0, 8'd255, 4'h5);
    run_phase(PHASE_ITEMS / 2);
    program_windows(8'd200, 8'd100, 8'd50, 8'd90, 4'hA);
    run_phase(PHASE_ITEMS);
    program_windows(8'd30, 8'd40, 8'd255, 8'd0, 4'h3);
    run_phase(PHASE_ITEMS / 2);
    program_windows(8'd255, 8'd0, 8'd255, 8'd0, 4'hC);
    run_phase(PHASE_ITEMS / 5);
    repeat (2) begin
      a = $urandom;
      b = $urandom;
      c = $urandom;
      d = $urandom;
      if ($urandom_range(3, 0) != 0) begin
        if (a > b) {a, b} = {b, a};
        if (c > d) {c, d} = {d, c};
      end
      program_windows(a, b, c, d, PRE_W'($urandom));
      run_phase(PHASE_ITEMS);
    end
  endtask

  task automatic test_steady_stream();
    program_windows(LONG_MIN_RST, LONG_MAX_RST, SHORT_MIN_RST, SHORT_MAX_RST, PREAMBLE_RST);
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(4, 0) == 0) send_noise($urandom_range(6, 1));
      else send_frame();
    end
  endtask

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (rx_stalls_on && $urandom_range(5, 0) == 0) begin
      stall_left <= $urandom_range(7, 0);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    frame_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (frames_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected frame result: status %0d data %h", out_tuser, out_tdata);
      end else begin
        exp_r = frames_due.pop_front();
        if (out_tuser !== exp_r.status || out_tdata !== exp_r.data) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("frame result mismatch: expected status %0d data %h, got status %0d data %h",
                     exp_r.status, exp_r.data, out_tuser, out_tdata);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n        <= 1'b0;
    cfg_valid    <= 1'b0;
    cfg_addr     <= CFG_LONG_MIN;
    cfg_data     <= '0;
    in_tvalid    <= 1'b0;
    in_tdata     <= '0;
    in_tuser     <= '0;
    items_sent   = 0;
    results_seen = 0;
    mismatches   = 0;
    frames_built = 0;
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
    windows      = {LONG_MIN_RST, LONG_MAX_RST, SHORT_MIN_RST, SHORT_MAX_RST, PREAMBLE_RST};
    frame_on     = 1'b0;
    clear_frame_state();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_windows();
    test_overlapping_windows();
    test_window_settings();
    test_steady_stream();

    in_tvalid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
